>>> src/decimal_int32_parse_check_unit_macros.svh
// Assertion macros for the decimal token parser.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DECIMAL_INT32_PARSE_CHECK_UNIT_MACROS_SVH
`define DECIMAL_INT32_PARSE_CHECK_UNIT_MACROS_SVH
`ifndef SYNTH
`define DIC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define DIC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define DIC_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define DIC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> src/dic_pkg.sv
// Shared types and constants for the decimal token parser.
// No dependencies.
package dic_pkg;

	localparam int CH_W  = 8;
	localparam int VAL_W = 32;
	localparam int MAG_W = 32;
	localparam int ACC_W = MAG_W + 4;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	localparam logic [CH_W-1:0] CH_END   = 8'h00;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

	localparam logic [MAG_W-1:0] MAG_MAX   = 32'hFFFF_FFFF;
	localparam logic [MAG_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [MAG_W-1:0] NEG_LIMIT = 32'h8000_0000;

endpackage

>>> src/dic_if.sv
// Request channel interfaces for the decimal token parser.
// Depends on dic_pkg for payload widths.
interface dic_in_if import dic_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface dic_out_if import dic_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    bad;

	modport source (output valid, output value, output bad, input ready);
	modport sink (input valid, input value, input bad, output ready);
endinterface

>>> src/decimal_int32_parse_check_unit.sv
// Top level of the decimal token parser: byte stream in, value and bad flag out.
// Depends on dic_pkg, dic_if.sv and decimal_int32_parse_check_unit_macros.svh.
//
// Usage:
//   chars carries one ASCII byte per request. Bytes accumulate into a token;
//   a zero byte ends it and produces one request on results with the signed
//   value and a bad flag (value is zero when bad). Other bytes give nothing.
//   Path: a byte is registered in stage 1 and folded into the token state
//   when it advances out of stage 1; the result for an ending byte is loaded
//   into the result register at that same edge, and results is driven
//   directly from that register.
//   Throughput: one byte per cycle unless an ending byte waits in stage 1. The
//   multiply-by-ten-and-add is combinational: state is ready for the next byte.
//   Stall: a held result blocks only an ending byte in stage 1; digits and
//   signs keep flowing. chars.ready falls once stage 1 holds an ending byte
//   that cannot move into the occupied result register.
//   Reset: arst_n clears the stage 1 and result valid flags and returns the
//   token state to token start.
`include "decimal_int32_parse_check_unit_macros.svh"

module decimal_int32_parse_check_unit import dic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dic_in_if.sink      chars,
	dic_out_if.source   results
);

	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;

	phase_t          phase_q;
	logic            negative_q;
	logic [MAG_W-1:0] magnitude_q;
	logic            too_large_q;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_bad_q;

	phase_t           phase_d;
	logic             negative_d;
	logic [MAG_W-1:0] magnitude_d;
	logic             too_large_d;

	logic                    is_end;
	logic                    advance;
	logic [ACC_W-1:0]        acc;
	logic [3:0]              digit;
	logic                    r_bad;
	logic signed [VAL_W-1:0] r_value;

	assign is_end  = (ch_s1 == CH_END);
	assign advance = valid_s1 && (!is_end || !res_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1 <= chars.ch;
		end
	end

	// token state next value
	always_comb begin
		digit = 4'(ch_s1 - CH_ZERO);
		acc   = ({{(ACC_W-MAG_W){1'b0}}, magnitude_q} << 3)
			+ {{(ACC_W-MAG_W-1){1'b0}}, magnitude_q, 1'b0}
			+ {{(ACC_W-4){1'b0}}, digit};
		phase_d     = phase_q;
		negative_d  = negative_q;
		magnitude_d = magnitude_q;
		too_large_d = too_large_q;
		if (is_end) begin
			phase_d     = PH_START;
			negative_d  = 1'b0;
			magnitude_d = '0;
			too_large_d = 1'b0;
		end else if (phase_q != PH_BAD) begin
			if (ch_s1 >= CH_ZERO && ch_s1 <= CH_NINE) begin
				phase_d = PH_DIGITS;
				if (acc > {{(ACC_W-MAG_W){1'b0}}, MAG_MAX}) begin
					magnitude_d = MAG_MAX;
					too_large_d = 1'b1;
				end else begin
					magnitude_d = acc[MAG_W-1:0];
				end
			end else if ((ch_s1 == CH_PLUS || ch_s1 == CH_MINUS) && phase_q == PH_START) begin
				phase_d    = PH_SIGN;
				negative_d = (ch_s1 == CH_MINUS);
			end else begin
				phase_d = PH_BAD;
			end
		end
	end

	// result for an ending byte
	always_comb begin
		r_bad = (phase_q != PH_DIGITS) || too_large_q
			|| (magnitude_q > (negative_q ? NEG_LIMIT : POS_LIMIT));
		if (r_bad) begin
			r_value = '0;
		end else if (negative_q) begin
			r_value = -$signed(magnitude_q);
		end else begin
			r_value = $signed(magnitude_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			negative_q  <= 1'b0;
			magnitude_q <= '0;
			too_large_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			negative_q  <= negative_d;
			magnitude_q <= magnitude_d;
			too_large_q <= too_large_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			res_value_q <= r_value;
			res_bad_q   <= r_bad;
		end
	end

	assign results.valid = res_valid_q;
	assign results.value = res_value_q;
	assign results.bad   = res_bad_q;

	`DIC_ASSERT_IMPLY(a_bad_zero, clk, arst_n, res_valid_q && res_bad_q, res_value_q == '0)
	`DIC_ASSERT_NEXT(a_end_clears, clk, arst_n, advance && is_end, phase_q == PH_START && magnitude_q == '0)
	`DIC_ASSERT_NEXT(a_end_held, clk, arst_n, valid_s1 && is_end && res_valid_q && !results.ready, valid_s1 && is_end)
	`DIC_ASSERT_IMPLY(a_sat_flag, clk, arst_n, too_large_q, magnitude_q == MAG_MAX)

endmodule

>>> tb/tb_decimal_int32_parse_check_unit.sv
// Self-checking bench for decimal_int32_parse_check_unit: directed tokens, then random token streams.
// Results are checked against fixed values or an in-bench parser; random stalls on both channels.
// Depends on dic_pkg, dic_if.sv and the RTL of the top level.
module tb_decimal_int32_parse_check_unit;
	import dic_pkg::*;

	localparam int LIMIT      = 200000;
	localparam int RAND_ITEMS = 1150;
	localparam int DRAIN      = 8;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    bad;
	} tok_result_t;

	typedef struct {
		logic [CH_W-1:0] ch;
		bit              fixed;
		tok_result_t     res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	dic_in_if  chars_if ();
	dic_out_if results_if ();

	decimal_int32_parse_check_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	phase_t           tok_phase;
	logic             tok_neg;
	logic [MAG_W-1:0] tok_mag;
	logic             tok_ovf;

	tok_result_t     pending_results[$];
	dir_row_t        dir_rows[$];
	logic [CH_W-1:0] token_bytes[$];

	int cycle_count = 0;
	int failures    = 0;
	int bytes_sent  = 0;
	int live_bytes  = 0;
	int tokens_seen = 0;
	int bad_seen    = 0;
	int tx_calm     = 0;
	int rx_calm     = 0;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("[decimal_int32_parse_check_unit] ERROR");
		$finish;
	end

	function void clear_token();
		tok_phase = PH_START;
		tok_neg   = 1'b0;
		tok_mag   = '0;
		tok_ovf   = 1'b0;
	endfunction

	// Returns 1 when the byte ends a token; r then holds the expected result.
	function automatic bit parse_byte(input logic [CH_W-1:0] c, output tok_result_t r);
		logic [63:0]      acc;
		logic [MAG_W-1:0] lim;
		r = '0;
		if (c == CH_END) begin
			r.bad = (tok_phase != PH_DIGITS) || tok_ovf;
			lim = tok_neg ? NEG_LIMIT : POS_LIMIT;
			if (!r.bad && tok_mag > lim)
				r.bad = 1'b1;
			if (!r.bad)
				r.value = tok_neg ? -tok_mag : tok_mag;
			clear_token();
			return 1'b1;
		end
		if (tok_phase == PH_BAD)
			return 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			acc = {32'b0, tok_mag} * 64'd10 + 64'(c - CH_ZERO);
			if (acc > {32'b0, MAG_MAX}) begin
				acc = {32'b0, MAG_MAX};
				tok_ovf = 1'b1;
			end
			tok_mag   = acc[MAG_W-1:0];
			tok_phase = PH_DIGITS;
		end else if ((c == CH_PLUS || c == CH_MINUS) && tok_phase == PH_START) begin
			tok_neg   = (c == CH_MINUS);
			tok_phase = PH_SIGN;
		end else begin
			tok_phase = PH_BAD;
		end
		return 1'b0;
	endfunction

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 3) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic void add_token(input string s, input bit fixed,
			input logic signed [VAL_W-1:0] v, input logic b);
		dir_row_t row;
		for (int i = 0; i < s.len(); i++) begin
			row.ch    = s[i];
			row.fixed = 1'b0;
			row.res   = '0;
			dir_rows.push_back(row);
		end
		row.ch        = CH_END;
		row.fixed     = fixed;
		row.res.value = v;
		row.res.bad   = b;
		dir_rows.push_back(row);
	endfunction

	function automatic void push_decimal(input longint unsigned v);
		logic [CH_W-1:0] digits[$];
		do begin
			digits.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i])
			token_bytes.push_back(digits[i]);
	endfunction

	function automatic void build_token();
		int              kind;
		int              n;
		int              pos;
		longint unsigned corner;
		logic [CH_W-1:0] junk;
		token_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			case ($urandom_range(0, 2))
				1: token_bytes.push_back(CH_PLUS);
				2: token_bytes.push_back(CH_MINUS);
				default: ;
			endcase
		end else if (kind >= 75) begin
			n = $urandom_range(1, 6);
			repeat (n) token_bytes.push_back(8'($urandom_range(1, 255)));
		end else begin
			case ($urandom_range(0, 2))
				1: token_bytes.push_back(CH_PLUS);
				2: token_bytes.push_back(CH_MINUS);
				default: ;
			endcase
			n = $urandom_range(0, 9);
			if (n < 3) begin
				case ($urandom_range(0, 8))
					0: corner = 64'd0;
					1: corner = 64'd1;
					2: corner = 64'd2147483646;
					3: corner = 64'd2147483647;
					4: corner = 64'd2147483648;
					5: corner = 64'd2147483649;
					6: corner = 64'd4294967295;
					7: corner = 64'd4294967296;
					default: corner = 64'd99999999999;
				endcase
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) token_bytes.push_back(CH_ZERO);
				push_decimal(corner);
			end else begin
				n = (n == 3) ? $urandom_range(11, 25) : $urandom_range(1, 9);
				repeat (n) token_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if (kind >= 60) begin
				pos = $urandom_range(1, token_bytes.size());
				case ($urandom_range(0, 2))
					0: junk = CH_PLUS;
					1: junk = CH_MINUS;
					default: junk = 8'($urandom_range(1, 255));
				endcase
				token_bytes.insert(pos, junk);
			end
		end
	endfunction

	// Entered and left at a falling edge.
	task automatic send_byte(input logic [CH_W-1:0] c, input bit fixed,
			input tok_result_t fixed_res);
		int          gap;
		tok_result_t r;
		bit          live;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= c;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		live = (tok_phase != PH_BAD) || (c == CH_END);
		if (parse_byte(c, r))
			pending_results.push_back(fixed ? fixed_res : r);
		bytes_sent++;
		if (live)
			live_bytes++;
		@(negedge clk);
	endtask

	initial begin : result_sink
		int          gap;
		tok_result_t exp_res;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				results_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid) @(posedge clk);
			tokens_seen++;
			if (results_if.bad)
				bad_seen++;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: value=%0d bad=%0b", results_if.value,
						results_if.bad);
			end else begin
				exp_res = pending_results.pop_front();
				if (exp_res.value !== results_if.value || exp_res.bad !== results_if.bad) begin
					failures++;
					if (failures <= 10)
						$display("result %0d mismatch: expected value=%0d bad=%0b, got value=%0d bad=%0b",
							tokens_seen, exp_res.value, exp_res.bad, results_if.value,
							results_if.bad);
				end
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int rand_start;
		chars_if.valid = 1'b0;
		chars_if.ch    = '0;
		arst_n         = 1'b0;
		clear_token();

		add_token("", 1'b1, 0, 1'b1);
		add_token("+", 1'b1, 0, 1'b1);
		add_token("-0", 1'b1, 0, 1'b0);
		add_token("1-", 1'b1, 0, 1'b1);
		add_token("\377", 1'b1, 0, 1'b1);
		add_token("-2147483648", 1'b1, 32'sh8000_0000, 1'b0);
		add_token("7", 1'b0, 0, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].res);

		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RAND_ITEMS) begin
			build_token();
			foreach (token_bytes[i])
				send_byte(token_bytes[i], 1'b0, '0);
			send_byte(CH_END, 1'b0, '0);
		end
		chars_if.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d bytes (%0d parsed), checked %0d tokens, %0d of them flagged bad",
			bytes_sent, live_bytes, tokens_seen, bad_seen);
		$display("failures: %0d in %0d cycles", failures, cycle_count);
		if (failures == 0)
			$display("[decimal_int32_parse_check_unit] OK");
		else
			$display("[decimal_int32_parse_check_unit] ERROR");
		$finish;
	end

endmodule
